### rtl/psc_pkg.sv
// Package for the polygon scissor clipper: constants, codes and state encoding.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    // Default sizing of the vertex stores and position fixed point
    localparam int MAX_IN_VERTS_DEF  = 16;
    localparam int MAX_OUT_VERTS_DEF = 48;
    localparam int POS_FRAC_BITS_DEF = 4;

    // Field widths and ranges
    localparam int POS_W   = 20;
    localparam int TEX_W   = 18;
    localparam int OFS_W   = 16;
    localparam int POS_MAX = 524287;
    localparam int POS_MIN = -524288;
    localparam int TEX_MAX = 131071;
    localparam int TEX_MIN = -131072;

    localparam int MIN_POLY_VERTS = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCISSOR_EN  = 3'd0,
        CFG_BYPASS      = 3'd1,
        CFG_CLIP_LEFT   = 3'd2,
        CFG_CLIP_TOP    = 3'd3,
        CFG_CLIP_RIGHT  = 3'd4,
        CFG_CLIP_BOTTOM = 3'd5
    } t_cfg_idx;

    // Clip planes in pass order
    typedef enum logic [1:0] {
        PL_TOP    = 2'd0,
        PL_BOTTOM = 2'd1,
        PL_LEFT   = 2'd2,
        PL_RIGHT  = 2'd3
    } t_plane;

    // Sequencer states, one-hot
    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_DECIDE  = 17'h00002,
        S_PSTART  = 17'h00004,
        S_SLOAD   = 17'h00008,
        S_EVAL    = 17'h00010,
        S_MUL     = 17'h00020,
        S_DIVINIT = 17'h00040,
        S_DIV     = 17'h00080,
        S_FIN     = 17'h00100,
        S_PUTX    = 17'h00200,
        S_PUTE    = 17'h00400,
        S_NEXT    = 17'h00800,
        S_PEND    = 17'h01000,
        S_EMDEC   = 17'h02000,
        S_CULL    = 17'h04000,
        S_EMRD    = 17'h08000,
        S_EMLD    = 17'h10000
    } t_state;

endpackage

`default_nettype wire

### rtl/polygon_scissor_clipper.sv
// Polygon scissor clipper: vertex gather, Sutherland-Hodgman clip, vertex emit.
// Loading: one vertex per cycle while idle; the last vertex starts the clip.
// Clip: one pass per plane; each crossing computes its interpolated vertex
//   with the shared restoring divider.
// Emit: each result is read from the registered vertex store port before it is output.
// Reset: synchronous; clears control, counters and registers, store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module polygon_scissor_clipper
    import psc_pkg::*;
#(
    parameter int MAX_IN_VERTS  = MAX_IN_VERTS_DEF,
    parameter int MAX_OUT_VERTS = MAX_OUT_VERTS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    // vertex input
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [POS_W-1:0] i_in_pos_x,
    input  logic signed [POS_W-1:0] i_in_pos_y,
    input  logic signed [TEX_W-1:0] i_in_tex_u,
    input  logic signed [TEX_W-1:0] i_in_tex_v,
    input  logic signed [OFS_W-1:0] i_translate_x,
    input  logic signed [OFS_W-1:0] i_translate_y,
    input  logic                    i_last_vertex,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [POS_W-1:0] o_out_pos_x,
    output logic signed [POS_W-1:0] o_out_pos_y,
    output logic signed [TEX_W-1:0] o_out_tex_u,
    output logic signed [TEX_W-1:0] o_out_tex_v,
    output logic                    o_polygon_culled,
    output logic                    o_clip_overflow,
    output logic                    o_last_of_run
);

    localparam int MAXV  = (MAX_IN_VERTS > MAX_OUT_VERTS) ? MAX_IN_VERTS : MAX_OUT_VERTS;
    localparam int IW    = $clog2(MAXV);
    localparam int CW    = $clog2(MAXV + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int EW    = (OFS_W + POS_FRAC_BITS > POS_W) ? OFS_W + POS_FRAC_BITS : POS_W;
    localparam int NW    = EW + 1;
    localparam int DW    = POS_W + 1;
    localparam int PW    = DW + NW;
    localparam int QW    = POS_W + 1;
    localparam int RW    = DW + 1;
    localparam int KW    = $clog2(QW);

    localparam logic signed [NW-1:0] SUM_HI = NW'(POS_MAX);
    localparam logic signed [NW-1:0] SUM_LO = NW'(POS_MIN);
    localparam logic signed [RW-1:0] RP_HI  = RW'(POS_MAX);
    localparam logic signed [RW-1:0] RP_LO  = RW'(POS_MIN);
    localparam logic signed [RW-1:0] RT_HI  = RW'(TEX_MAX);
    localparam logic signed [RW-1:0] RT_LO  = RW'(TEX_MIN);

    // vertex stores: {bank, index}
    logic [2*POS_W-1:0] position_store [DEPTH];
    logic [2*TEX_W-1:0] texcoord_store [DEPTH];

    t_state r_state, n_state;

    logic                   r_scissor_en, r_bypass;
    logic signed [OFS_W-1:0] r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;

    logic [CW-1:0] r_count, r_n, r_m, r_i;
    logic          r_bank, r_ovf;
    t_plane        r_plane;

    logic [2*POS_W-1:0] r_rd_pos;
    logic [2*TEX_W-1:0] r_rd_tex;

    logic signed [POS_W-1:0] r_s_c [4];
    logic signed [POS_W-1:0] r_e_c [4];
    logic signed [POS_W-1:0] r_x_c [4];
    logic                    r_s_in, r_e_in;
    logic signed [NW-1:0]    r_num;
    logic signed [DW-1:0]    r_den;
    logic [1:0]              r_k;

    // divider state
    logic signed [PW-1:0] r_prod;
    logic [DW-1:0]        r_ad;
    logic                 r_neg;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_dlo, r_q;
    logic [KW-1:0]        r_dcnt;

    // output register
    logic                    r_out_valid, r_culled, r_out_ovf, r_last;
    logic signed [POS_W-1:0] r_o_x, r_o_y;
    logic signed [TEX_W-1:0] r_o_u, r_o_v;

    // memory port controls
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [2*POS_W-1:0] wr_pos;
    logic [2*TEX_W-1:0] wr_tex;

    // unpacked read data
    logic signed [POS_W-1:0] rd_c [4];
    assign rd_c[0] = r_rd_pos[POS_W-1:0];
    assign rd_c[1] = r_rd_pos[2*POS_W-1:POS_W];
    assign rd_c[2] = POS_W'($signed(r_rd_tex[TEX_W-1:0]));
    assign rd_c[3] = POS_W'($signed(r_rd_tex[2*TEX_W-1:TEX_W]));

    logic in_acc, out_free, clip_on, put_full, n_short, last_i, plane_last;
    logic [CW-1:0] nm1, ip1;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign clip_on    = r_scissor_en && !r_bypass;
    assign put_full   = r_m >= CW'(MAX_OUT_VERTS);
    assign n_short    = r_n < CW'(MIN_POLY_VERTS);
    assign nm1        = r_n - CW'(1);
    assign ip1        = r_i + CW'(1);
    assign last_i     = r_i == nm1;
    assign plane_last = r_plane == PL_RIGHT;

    // translated input position, saturated
    logic signed [NW-1:0]    sum_x, sum_y;
    logic signed [POS_W-1:0] sat_x, sat_y;
    assign sum_x = NW'(i_in_pos_x) + (NW'(i_translate_x) <<< POS_FRAC_BITS);
    assign sum_y = NW'(i_in_pos_y) + (NW'(i_translate_y) <<< POS_FRAC_BITS);
    assign sat_x = (sum_x > SUM_HI) ? POS_W'(POS_MAX) :
                   (sum_x < SUM_LO) ? POS_W'(POS_MIN) : sum_x[POS_W-1:0];
    assign sat_y = (sum_y > SUM_HI) ? POS_W'(POS_MAX) :
                   (sum_y < SUM_LO) ? POS_W'(POS_MIN) : sum_y[POS_W-1:0];

    // plane level and inside test on the vertex just read
    logic signed [OFS_W-1:0] plane_reg;
    logic signed [EW-1:0]    plane_lvl;
    logic                    axis_y, incl;
    logic signed [POS_W-1:0] rd_ax, s_ax;
    logic                    rd_in;
    always_comb begin
        unique case (r_plane)
            PL_TOP:    plane_reg = r_clip_top;
            PL_BOTTOM: plane_reg = r_clip_bottom;
            PL_LEFT:   plane_reg = r_clip_left;
            default:   plane_reg = r_clip_right;
        endcase
    end
    assign plane_lvl = EW'(plane_reg) <<< POS_FRAC_BITS;
    assign axis_y    = (r_plane == PL_TOP) || (r_plane == PL_BOTTOM);
    assign incl      = (r_plane == PL_TOP) || (r_plane == PL_LEFT);
    assign rd_ax     = axis_y ? rd_c[1] : rd_c[0];
    assign s_ax      = axis_y ? r_s_c[1] : r_s_c[0];
    assign rd_in     = incl ? (EW'(rd_ax) >= plane_lvl) : (EW'(rd_ax) < plane_lvl);

    // divider step and final interpolated value
    logic [RW-1:0]        rem_sh;
    logic                 rem_ge;
    logic [PW-1:0]        an;
    logic [DW-1:0]        ad;
    logic [PW:0]          an_r;
    logic signed [RW-1:0] q_s, a_s, res, lo_v, hi_v;
    logic signed [DW-1:0] diff;
    assign rem_sh = {r_rem[RW-2:0], r_dlo[QW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_ad};
    assign an     = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign ad     = r_den[DW-1] ? DW'(-r_den) : DW'(r_den);
    assign an_r   = (PW+1)'(an) + (PW+1)'(ad >> 1);
    assign q_s    = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign a_s    = RW'(r_s_c[r_k]);
    assign res    = a_s + q_s;
    assign hi_v   = (r_k < 2'd2) ? RP_HI : RT_HI;
    assign lo_v   = (r_k < 2'd2) ? RP_LO : RT_LO;
    assign diff   = DW'(r_e_c[r_k]) - DW'(r_s_c[r_k]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc && i_last_vertex) n_state = S_DECIDE;
            S_DECIDE:  n_state = clip_on ? S_PSTART : S_EMDEC;
            S_PSTART:  n_state = !n_short ? S_SLOAD : (plane_last ? S_EMDEC : S_PSTART);
            S_SLOAD:   n_state = S_EVAL;
            S_EVAL:    n_state = (rd_in != r_s_in) ? S_MUL : (rd_in ? S_PUTE : S_NEXT);
            S_MUL:     n_state = S_DIVINIT;
            S_DIVINIT: n_state = S_DIV;
            S_DIV:     if (r_dcnt == KW'(QW - 1)) n_state = S_FIN;
            S_FIN:     n_state = (r_k == 2'd3) ? S_PUTX : S_MUL;
            S_PUTX:    n_state = r_e_in ? S_PUTE : S_NEXT;
            S_PUTE:    n_state = S_NEXT;
            S_NEXT:    n_state = last_i ? S_PEND : S_EVAL;
            S_PEND:    n_state = plane_last ? S_EMDEC : S_PSTART;
            S_EMDEC:   n_state = (clip_on && n_short) ? S_CULL : S_EMRD;
            S_CULL:    if (out_free) n_state = S_IDLE;
            S_EMRD:    n_state = S_EMLD;
            S_EMLD:    if (out_free) n_state = last_i ? S_IDLE : S_EMRD;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory port selection; passes read one bank and write the other
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {1'b0, r_count[IW-1:0]};
        wr_pos  = {sat_y, sat_x};
        wr_tex  = {i_in_tex_v, i_in_tex_u};
        rd_en   = 1'b0;
        rd_addr = {r_bank, r_i[IW-1:0]};
        case (r_state)
            S_IDLE: wr_en = in_acc && (r_count < CW'(MAX_IN_VERTS));
            S_PUTX: begin
                wr_en   = !put_full;
                wr_addr = {~r_bank, r_m[IW-1:0]};
                wr_pos  = {r_x_c[1], r_x_c[0]};
                wr_tex  = {r_x_c[3][TEX_W-1:0], r_x_c[2][TEX_W-1:0]};
            end
            S_PUTE: begin
                wr_en   = !put_full;
                wr_addr = {~r_bank, r_m[IW-1:0]};
                wr_pos  = {r_e_c[1], r_e_c[0]};
                wr_tex  = {r_e_c[3][TEX_W-1:0], r_e_c[2][TEX_W-1:0]};
            end
            S_PSTART: begin
                rd_en   = !n_short;
                rd_addr = {r_bank, nm1[IW-1:0]};
            end
            S_SLOAD: begin
                rd_en   = 1'b1;
                rd_addr = {r_bank, {IW{1'b0}}};
            end
            S_NEXT: begin
                rd_en   = 1'b1;
                rd_addr = {r_bank, ip1[IW-1:0]};
            end
            S_EMRD: rd_en = 1'b1;
            default: ;
        endcase
    end

    // vertex stores
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            position_store[wr_addr] <= wr_pos;
            texcoord_store[wr_addr] <= wr_tex;
        end
        if (rd_en) begin
            r_rd_pos <= position_store[rd_addr];
            r_rd_tex <= texcoord_store[rd_addr];
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_scissor_en  <= 1'b0;
            r_bypass      <= 1'b0;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= '0;
            r_clip_bottom <= '0;
            r_count       <= '0;
            r_n           <= '0;
            r_m           <= '0;
            r_i           <= '0;
            r_ovf         <= 1'b0;
            r_bank        <= 1'b0;
            r_plane       <= PL_TOP;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SCISSOR_EN:  r_scissor_en  <= i_cfg_wdata[0];
                    CFG_BYPASS:      r_bypass      <= i_cfg_wdata[0];
                    CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_wdata;
                    CFG_CLIP_TOP:    r_clip_top    <= i_cfg_wdata;
                    CFG_CLIP_RIGHT:  r_clip_right  <= i_cfg_wdata;
                    CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_count < CW'(MAX_IN_VERTS)) r_count <= r_count + CW'(1);
                        else r_ovf <= 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_n     <= r_count;
                    r_bank  <= 1'b0;
                    r_plane <= PL_TOP;
                    if (!clip_on && (r_count > CW'(MAX_OUT_VERTS))) begin
                        r_n   <= CW'(MAX_OUT_VERTS);
                        r_ovf <= 1'b1;
                    end
                end
                S_PSTART: begin
                    r_m <= '0;
                    r_i <= '0;
                    if (n_short && !plane_last) r_plane <= t_plane'(r_plane + 2'd1);
                end
                S_SLOAD: begin
                    r_s_c  <= rd_c;
                    r_s_in <= rd_in;
                end
                S_EVAL: begin
                    r_e_c  <= rd_c;
                    r_e_in <= rd_in;
                    r_num  <= NW'(plane_lvl) - NW'(s_ax);
                    r_den  <= DW'(rd_ax) - DW'(s_ax);
                    r_k    <= 2'd0;
                end
                S_MUL: r_prod <= PW'(diff) * PW'(r_num);
                S_DIVINIT: begin
                    r_ad   <= ad;
                    r_neg  <= r_prod[PW-1] ^ r_den[DW-1];
                    r_rem  <= an_r[QW +: RW];
                    r_dlo  <= an_r[QW-1:0];
                    r_q    <= '0;
                    r_dcnt <= '0;
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? RW'(rem_sh - {1'b0, r_ad}) : rem_sh;
                    r_q    <= {r_q[QW-2:0], rem_ge};
                    r_dlo  <= {r_dlo[QW-2:0], 1'b0};
                    r_dcnt <= r_dcnt + KW'(1);
                end
                S_FIN: begin
                    r_x_c[r_k] <= (res > hi_v) ? hi_v[POS_W-1:0] :
                                  (res < lo_v) ? lo_v[POS_W-1:0] : res[POS_W-1:0];
                    r_k <= r_k + 2'd1;
                end
                S_PUTX, S_PUTE: begin
                    if (put_full) r_ovf <= 1'b1;
                    else r_m <= r_m + CW'(1);
                end
                S_NEXT: begin
                    r_s_c  <= r_e_c;
                    r_s_in <= r_e_in;
                    r_i    <= ip1;
                end
                S_PEND: begin
                    r_n    <= r_m;
                    r_bank <= ~r_bank;
                    if (!plane_last) r_plane <= t_plane'(r_plane + 2'd1);
                end
                S_EMDEC: r_i <= '0;
                S_CULL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_x       <= '0;
                        r_o_y       <= '0;
                        r_o_u       <= '0;
                        r_o_v       <= '0;
                        r_culled    <= 1'b1;
                        r_out_ovf   <= r_ovf;
                        r_last      <= 1'b1;
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                    end
                end
                S_EMLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_x       <= rd_c[0];
                        r_o_y       <= rd_c[1];
                        r_o_u       <= rd_c[2][TEX_W-1:0];
                        r_o_v       <= rd_c[3][TEX_W-1:0];
                        r_culled    <= 1'b0;
                        r_out_ovf   <= r_ovf;
                        r_last      <= last_i;
                        r_i         <= ip1;
                        if (last_i) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall       = r_state != S_IDLE;
    assign o_out_valid      = r_out_valid;
    assign o_out_pos_x      = r_o_x;
    assign o_out_pos_y      = r_o_y;
    assign o_out_tex_u      = r_o_u;
    assign o_out_tex_v      = r_o_v;
    assign o_polygon_culled = r_culled;
    assign o_clip_overflow  = r_out_ovf;
    assign o_last_of_run    = r_last;

    // clip store never filled past its capacity
    a_m_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m <= CW'(MAX_OUT_VERTS))
        else $error("clip store fill beyond capacity");

    // a plane pass only runs on a real polygon
    a_pass_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOAD) |-> (r_n >= CW'(MIN_POLY_VERTS)))
        else $error("plane pass on short polygon");

    // pass writes go to the bank not being read
    a_bank_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && ((r_state == S_PUTX) || (r_state == S_PUTE))) |-> (wr_addr[AW-1] != r_bank))
        else $error("pass write into source bank");

    // a culled result is the last and carries no vertex
    a_cull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_polygon_culled) |-> (o_last_of_run && (o_out_pos_x == '0)))
        else $error("culled result malformed");

endmodule

`default_nettype wire

### tb/sv/tb_polygon_scissor_clipper.sv
// Testbench for the polygon scissor clipper: directed and random polygons checked against a predictor.
`timescale 1ns / 1ps

module tb_polygon_scissor_clipper;
    import psc_pkg::*;

    localparam int IN_CAP      = 16;
    localparam int OUT_CAP     = 48;
    localparam int FRAC        = 4;
    localparam int SETTLE      = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP7   = 3'd7;

    typedef struct {
        longint px, py, tu, tv;
        bit     lst;
    } vtx_t;

    typedef struct {
        logic signed [POS_W-1:0] px, py;
        logic signed [TEX_W-1:0] tu, tv;
        logic culled, ovf, lst;
    } clip_out_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [POS_W-1:0] i_in_pos_x = '0, i_in_pos_y = '0;
    logic signed [TEX_W-1:0] i_in_tex_u = '0, i_in_tex_v = '0;
    logic signed [OFS_W-1:0] i_translate_x = '0, i_translate_y = '0;
    logic i_last_vertex = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [POS_W-1:0] o_out_pos_x, o_out_pos_y;
    logic signed [TEX_W-1:0] o_out_tex_u, o_out_tex_v;
    logic o_polygon_culled, o_clip_overflow, o_last_of_run;

    polygon_scissor_clipper dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state: register mirror and two vertex banks
    bit      m_en, m_byp;
    longint  m_edge [4];
    longint  bx [2][64], by [2][64], bu [2][64], bv [2][64];
    int      vert_cnt;
    bit      ovf_flag;
    clip_out_t clipped_q [$];

    int  fail_cnt;
    bit  tx_idle_en, rx_idle_en;
    bit  tx_pending;
    int  rx_hold;
    int  rx_burst;

    function automatic longint sat_w(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // round to nearest, halves away from zero
    function automatic longint div_round(longint n, longint d);
        bit neg;
        longint an, ad;
        if (d == 0) return 0;
        neg = (n < 0) != (d < 0);
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        return neg ? -((an + ad / 2) / ad) : (an + ad / 2) / ad;
    endfunction

    function automatic bit vtx_in(int pl, int bk, int i);
        longint c;
        c = (pl == PL_TOP || pl == PL_BOTTOM) ? by[bk][i] : bx[bk][i];
        return (pl == PL_TOP || pl == PL_LEFT) ? (c >= m_edge[pl]) : (c < m_edge[pl]);
    endfunction

    function automatic void store_vtx(int bk, inout int m, input longint x, y, u, v);
        if (m >= OUT_CAP) begin
            ovf_flag = 1'b1;
            return;
        end
        bx[bk][m] = x; by[bk][m] = y; bu[bk][m] = u; bv[bk][m] = v;
        m++;
    endfunction

    // one Sutherland-Hodgman pass from bank src into the other bank
    function automatic int plane_pass(int pl, int n, inout int src);
        int dst, m, s;
        bit s_in, e_in, on_y;
        longint num, den, a0, a1;
        if (n < MIN_POLY_VERTS) return n;
        dst = src ^ 1;
        m = 0;
        on_y = (pl == PL_TOP || pl == PL_BOTTOM);
        s = n - 1;
        s_in = vtx_in(pl, src, s);
        for (int i = 0; i < n; i++) begin
            e_in = vtx_in(pl, src, i);
            if (e_in != s_in) begin
                a0 = on_y ? by[src][s] : bx[src][s];
                a1 = on_y ? by[src][i] : bx[src][i];
                num = m_edge[pl] - a0;
                den = a1 - a0;
                store_vtx(dst, m,
                    sat_w(bx[src][s] + div_round((bx[src][i] - bx[src][s]) * num, den), POS_W),
                    sat_w(by[src][s] + div_round((by[src][i] - by[src][s]) * num, den), POS_W),
                    sat_w(bu[src][s] + div_round((bu[src][i] - bu[src][s]) * num, den), TEX_W),
                    sat_w(bv[src][s] + div_round((bv[src][i] - bv[src][s]) * num, den), TEX_W));
            end
            if (e_in) store_vtx(dst, m, bx[src][i], by[src][i], bu[src][i], bv[src][i]);
            s = i;
            s_in = e_in;
        end
        src = dst;
        return m;
    endfunction

    // gather one accepted vertex; on the last one queue the clipped polygon
    function automatic void predict_vertex(vtx_t vt, longint tx, longint ty);
        int n, bk;
        bit clip_on;
        clip_out_t r;
        if (vert_cnt < IN_CAP) begin
            bx[0][vert_cnt] = sat_w(vt.px + tx * (1 << FRAC), POS_W);
            by[0][vert_cnt] = sat_w(vt.py + ty * (1 << FRAC), POS_W);
            bu[0][vert_cnt] = vt.tu;
            bv[0][vert_cnt] = vt.tv;
            vert_cnt++;
        end else begin
            ovf_flag = 1'b1;
        end
        if (!vt.lst) return;
        n = vert_cnt;
        bk = 0;
        clip_on = m_en && !m_byp;
        if (clip_on) begin
            for (int p = 0; p < 4; p++) n = plane_pass(p, n, bk);
        end else if (n > OUT_CAP) begin
            n = OUT_CAP;
            ovf_flag = 1'b1;
        end
        if (clip_on && n < MIN_POLY_VERTS) begin
            r = '{px: '0, py: '0, tu: '0, tv: '0, culled: 1'b1, ovf: ovf_flag, lst: 1'b1};
            clipped_q.push_back(r);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.px = bx[bk][i]; r.py = by[bk][i]; r.tu = bu[bk][i]; r.tv = bv[bk][i];
                r.culled = 1'b0; r.ovf = ovf_flag; r.lst = (i == n - 1);
                clipped_q.push_back(r);
            end
        end
        vert_cnt = 0;
        ovf_flag = 1'b0;
    endfunction

    // result checker and receiver stall generator
    always @(posedge i_clk) begin
        clip_out_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (clipped_q.size() == 0) begin
                $display("%0t unexpected result px=%0d py=%0d", $time, o_out_pos_x, o_out_pos_y);
                fail_cnt++;
            end else begin
                e = clipped_q.pop_front();
                if (o_out_pos_x !== e.px || o_out_pos_y !== e.py || o_out_tex_u !== e.tu ||
                    o_out_tex_v !== e.tv || o_polygon_culled !== e.culled ||
                    o_clip_overflow !== e.ovf || o_last_of_run !== e.lst) begin
                    $display("%0t mismatch exp px=%0d py=%0d u=%0d v=%0d c=%b o=%b l=%b",
                             $time, e.px, e.py, e.tu, e.tv, e.culled, e.ovf, e.lst);
                    $display("%0t          act px=%0d py=%0d u=%0d v=%0d c=%b o=%b l=%b",
                             $time, o_out_pos_x, o_out_pos_y, o_out_tex_u, o_out_tex_v,
                             o_polygon_culled, o_clip_overflow, o_last_of_run);
                    fail_cnt++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_out_stall <= 1'b1;
        end else begin
            if (rx_idle_en && $urandom_range(0, 5) == 0) rx_burst = $urandom_range(1, 11);
            i_out_stall <= 1'b0;
        end
    end

    // drop valid if a request is still being held up from the last send
    task automatic tx_release();
        if (tx_pending) i_in_valid <= 1'b0;
        tx_pending = 1'b0;
    endtask

    // send one vertex request and wait until it is taken
    task automatic send_vertex(vtx_t vt, longint tx, longint ty);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            tx_release();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_pos_x <= vt.px; i_in_pos_y <= vt.py;
        i_in_tex_u <= vt.tu; i_in_tex_v <= vt.tv;
        i_translate_x <= tx; i_translate_y <= ty;
        i_last_vertex <= vt.lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tx_pending = 1'b1;
        predict_vertex(vt, tx, ty);
    endtask

    task automatic drain();
        tx_release();
        @(posedge i_clk);
        while (clipped_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic void mirror_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
        case (idx)
            CFG_SCISSOR_EN:  m_en = d[0];
            CFG_BYPASS:      m_byp = d[0];
            CFG_CLIP_LEFT:   m_edge[PL_LEFT] = longint'(signed'(d)) * (1 << FRAC);
            CFG_CLIP_TOP:    m_edge[PL_TOP] = longint'(signed'(d)) * (1 << FRAC);
            CFG_CLIP_RIGHT:  m_edge[PL_RIGHT] = longint'(signed'(d)) * (1 << FRAC);
            CFG_CLIP_BOTTOM: m_edge[PL_BOTTOM] = longint'(signed'(d)) * (1 << FRAC);
            default: ;
        endcase
    endfunction

    // write all registers while the block is idle
    task automatic set_scissor(bit en, bit byp, int l, int t, int r, int b);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [15:0] val [6];
        drain();
        idx = '{CFG_SCISSOR_EN, CFG_BYPASS, CFG_CLIP_LEFT, CFG_CLIP_TOP,
                CFG_CLIP_RIGHT, CFG_CLIP_BOTTOM};
        val = '{{15'd0, en}, {15'd0, byp}, l[15:0], t[15:0], r[15:0], b[15:0]};
        for (int k = 0; k < 6; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_wdata <= val[k];
            mirror_cfg(idx[k], val[k]);
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic vtx_t mk(longint x, y, u, v, bit l);
        vtx_t vt;
        vt.px = x; vt.py = y; vt.tu = u; vt.tv = v; vt.lst = l;
        return vt;
    endfunction

    // random polygon around the scissor area, sometimes over the full range
    task automatic send_random_polygon(int nv);
        longint tx, ty, x, y;
        bit wide;
        wide = $urandom_range(0, 7) == 0;
        tx = wide ? $signed($urandom_range(0, 65535)) - 32768 : $signed($urandom_range(0, 20)) - 10;
        ty = wide ? $signed($urandom_range(0, 65535)) - 32768 : $signed($urandom_range(0, 20)) - 10;
        for (int i = 0; i < nv; i++) begin
            if (wide) begin
                x = longint'($urandom_range(0, 1048575)) - 524288;
                y = longint'($urandom_range(0, 1048575)) - 524288;
            end else begin
                x = longint'($urandom_range(0, 3200)) - 1600;
                y = longint'($urandom_range(0, 3200)) - 1600;
            end
            send_vertex(mk(x, y, longint'($urandom_range(0, 262143)) - 131072,
                           longint'($urandom_range(0, 262143)) - 131072, i == nv - 1), tx, ty);
        end
    endtask

    task automatic test_pass_through();
        set_scissor(0, 0, 0, 0, 0, 0);
        send_vertex(mk(POS_MAX, POS_MIN, TEX_MAX, TEX_MIN, 0), 0, 0);
        send_vertex(mk(POS_MIN, POS_MAX, TEX_MIN, TEX_MAX, 0), 0, 0);
        send_vertex(mk(0, 0, 0, 0, 1), 0, 0);
        // two and one vertex polygons pass translated and not culled
        send_vertex(mk(5, 6, 7, 8, 0), 3, -3);
        send_vertex(mk(-5, -6, -7, -8, 1), 3, -3);
        send_vertex(mk(100, 200, 300, 400, 1), -1, 1);
        // translation saturates both ways
        send_vertex(mk(POS_MAX, POS_MIN, 1, 1, 0), 32767, -32768);
        send_vertex(mk(POS_MIN, POS_MAX, 1, 1, 1), -32768, 32767);
    endtask

    task automatic test_bypass();
        set_scissor(1, 1, -10, -10, 10, 10);
        send_vertex(mk(-4000, -4000, 10, 20, 0), 0, 0);
        send_vertex(mk(4000, -4000, 30, 40, 0), 0, 0);
        send_vertex(mk(0, 4000, 50, 60, 1), 0, 0);
    endtask

    task automatic test_clip_planes();
        set_scissor(1, 0, -10, -8, 12, 9);
        // triangle crossing every plane
        send_vertex(mk(-400, -300, TEX_MIN, 0, 0), 0, 0);
        send_vertex(mk(500, -250, TEX_MAX, 1000, 0), 0, 0);
        send_vertex(mk(30, 400, 0, TEX_MAX, 1), 0, 0);
        // fully outside: culled
        send_vertex(mk(4000, 4000, 1, 1, 0), 0, 0);
        send_vertex(mk(5000, 4000, 1, 1, 0), 0, 0);
        send_vertex(mk(4500, 5000, 1, 1, 1), 0, 0);
        // on the inclusive edges and just inside the exclusive edges
        send_vertex(mk(-160, -128, 2, 3, 0), 0, 0);
        send_vertex(mk(191, -128, 4, 5, 0), 0, 0);
        send_vertex(mk(0, 143, 6, 7, 1), 0, 0);
        // two vertices with clipping on: passes skipped, culled
        send_vertex(mk(0, 0, 1, 1, 0), 0, 0);
        send_vertex(mk(10, 10, 1, 1, 1), 0, 0);
    endtask

    task automatic test_store_overflow();
        // input store overflow with a dropped last vertex, clip off then on
        set_scissor(0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 19; i++)
            send_vertex(mk(i * 16, i * 3, i, -i, i == 18), 0, 0);
        set_scissor(1, 0, -20, -20, 20, 20);
        // spiky star: many crossings per pass
        for (int i = 0; i < 18; i++) begin
            if (i[0]) send_vertex(mk(0, 0, i, i, i == 17), 0, 0);
            else send_vertex(mk((i % 4 < 2) ? 3000 : -3000, (i % 8 < 4) ? 3000 : -3000,
                                TEX_MAX, TEX_MIN, 0), 0, 0);
        end
        // unknown register indexes are ignored
        drain();
        i_cfg_wr_en <= 1'b1; i_cfg_idx <= CFG_IDX_UNUSED; i_cfg_wdata <= 16'hFFFF;
        @(posedge i_clk);
        i_cfg_idx <= CFG_IDX_TOP7;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        send_vertex(mk(-1000, -1000, 1, 2, 0), 0, 0);
        send_vertex(mk(1000, -1000, 3, 4, 0), 0, 0);
        send_vertex(mk(0, 1000, 5, 6, 1), 0, 0);
    endtask

    task automatic test_random();
        int sent;
        bit held;
        sent = 0;
        held = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (sent < 200) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 4))
                    0: set_scissor(1, 0, -32768, -32768, 32767, 32767);
                    1: set_scissor(1, 0, 20, 20, -20, -20);
                    2: set_scissor(0, $urandom_range(0, 1), 0, 0, 0, 0);
                    3: set_scissor(1, 1, 32767, 32767, -32768, -32768);
                    default: set_scissor(1, 0, -$urandom_range(0, 80), -$urandom_range(0, 80),
                                         $urandom_range(0, 80), $urandom_range(0, 80));
                endcase
            end
            if (!held && sent >= 80) begin
                // receiver holds off while the sender keeps offering vertices
                rx_hold = 400;
                tx_idle_en = 1'b0;
                held = 1'b1;
            end
            if (sent >= 150) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else if (sent > 110) begin
                tx_idle_en = 1'b1;
            end
            begin
                int nv;
                nv = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 8);
                send_random_polygon(nv);
                sent += nv;
            end
        end
    endtask

    initial begin
        int waited;
        fail_cnt = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pass_through();
        test_bypass();
        test_clip_planes();
        test_store_overflow();
        test_random();
        tx_release();
        waited = 0;
        while (clipped_q.size() != 0 && waited < 500000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (fail_cnt == 0 && clipped_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
